// ===== hw/rtl/v53lw_pkg.sv =====
// ----------------------------------------------------------------------------
// v53lw_pkg
// Shared constants, register indexes and control types for the vertical 5/3
// lifting wavelet.
// ----------------------------------------------------------------------------
package v53lw_pkg;

    localparam int SAMPLE_BITS_DEF = 18;
    localparam int MAX_WIDTH_DEF   = 256;
    localparam int HEIGHT_LIMIT    = 256;

    localparam int ROW_BITS       = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INVERSE_MODE = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] WIDTH_RESET  = 9'd256;
    localparam logic [CFG_DATA_BITS-1:0] HEIGHT_RESET = 9'd256;

    // Position and mode of one accepted sample
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic                last_row;
        logic                last_col;
        logic                inverse;
    } item_ctrl_t;

    // One group of results caused by a single sample (rows are consecutive)
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [7:0]          col;
        logic [1:0]          count;
        logic                frame;
    } grp_ctrl_t;

endpackage

// ===== hw/rtl/v53lw_if.sv =====
// ----------------------------------------------------------------------------
// v53lw_if
// Valid/ready channels for the sample input and the tagged result output.
// ----------------------------------------------------------------------------
interface v53lw_in_if #(
    parameter int SAMPLE_BITS = v53lw_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface v53lw_out_if #(
    parameter int SAMPLE_BITS = v53lw_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [7:0]                    out_row;
    logic [7:0]                    out_col;
    logic                          run_last;
    logic                          frame_done;

    modport source (output valid, output sample_out, output out_row, output out_col,
                    output run_last, output frame_done, input ready);
    modport sink   (input valid, input sample_out, input out_row, input out_col,
                    input run_last, input frame_done, output ready);
endinterface

// ===== hw/rtl/v53lw_core.sv =====
// ----------------------------------------------------------------------------
// v53lw_core
// Line stores and the two-stage lifting datapath. Stage one forms the
// predict (forward) or undo-update (inverse) value and writes the stores;
// stage two forms the remaining results of the group.
// ----------------------------------------------------------------------------
module v53lw_core #(
    parameter int MAX_WIDTH   = v53lw_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = v53lw_pkg::SAMPLE_BITS_DEF,
    parameter int COL_BITS    = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic [COL_BITS-1:0]           col_in,
    input  v53lw_pkg::item_ctrl_t         ctrl_in,
    output logic                          push,
    output v53lw_pkg::grp_ctrl_t          grp,
    output logic [3*SAMPLE_BITS-1:0]      vals,
    output logic [1:0]                    busy
);
    import v53lw_pkg::*;

    localparam int WB = SAMPLE_BITS + 3;
    localparam logic signed [WB-1:0] SAT_HI  = WB'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [WB-1:0] SAT_LO  = ~SAT_HI;
    localparam logic signed [WB-1:0] ROUND_Q = WB'(64'sd2);

    function automatic logic signed [WB-1:0] ext(input logic signed [SAMPLE_BITS-1:0] v);
        return WB'(v);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [WB-1:0] v);
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAMPLE_BITS'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            r = SAMPLE_BITS'(SAT_LO);
        end
        else
        begin
            r = SAMPLE_BITS'(v);
        end
        return r;
    endfunction

    // line stores
    logic signed [SAMPLE_BITS-1:0] even_mem   [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] odd_mem    [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] detail_mem [MAX_WIDTH];

    // stage one
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic [COL_BITS-1:0]           s1_col_reg;
    item_ctrl_t                    s1_ctrl_reg;
    logic signed [SAMPLE_BITS-1:0] ev_rd_reg;
    logic signed [SAMPLE_BITS-1:0] od_rd_reg;
    logic signed [SAMPLE_BITS-1:0] dt_rd_reg;

    logic                          s1_even;
    logic                          s1_fwd;
    logic                          use_self;
    logic                          emit;
    logic                          has_xo;
    logic signed [SAMPLE_BITS-1:0] d_pair;
    logic signed [SAMPLE_BITS-1:0] d_last;
    logic signed [SAMPLE_BITS-1:0] d_fwd;
    logic signed [SAMPLE_BITS-1:0] dp_inv;
    logic signed [SAMPLE_BITS-1:0] xe;
    logic                          even_we;
    logic                          odd_we;
    logic                          det_we;
    logic signed [SAMPLE_BITS-1:0] even_wd;
    logic signed [SAMPLE_BITS-1:0] det_wd;
    grp_ctrl_t                     grp_next;

    // stage two
    logic                          s2_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s2_a_reg;
    logic signed [SAMPLE_BITS-1:0] s2_c_reg;
    logic signed [SAMPLE_BITS-1:0] s2_dt_reg;
    logic signed [SAMPLE_BITS-1:0] s2_x_reg;
    logic                          s2_self_reg;
    logic                          s2_inv_reg;
    logic                          s2_xo_reg;
    grp_ctrl_t                     s2_grp_reg;

    logic signed [SAMPLE_BITS-1:0] s2_b;
    logic signed [SAMPLE_BITS-1:0] s_val;
    logic signed [SAMPLE_BITS-1:0] xo_val;
    logic signed [SAMPLE_BITS-1:0] fin_val;

    // ---- stage one decode and arithmetic ----
    always_comb
    begin
        s1_even  = !s1_ctrl_reg.row[0];
        s1_fwd   = !s1_ctrl_reg.inverse;
        use_self = (s1_ctrl_reg.row == 8'd1) || (s1_ctrl_reg.row == 8'd2);
        has_xo   = s1_ctrl_reg.row > 8'd1;

        if (s1_fwd)
        begin
            emit = (s1_even && (s1_ctrl_reg.row != 8'd0)) || (!s1_even && s1_ctrl_reg.last_row);
        end
        else
        begin
            emit = !s1_even;
        end

        d_pair = sat(ext(od_rd_reg) - ((ext(ev_rd_reg) + ext(s1_x_reg)) >>> 1));
        d_last = sat(ext(s1_x_reg) - ext(ev_rd_reg));
        d_fwd  = s1_even ? d_pair : d_last;
        dp_inv = use_self ? s1_x_reg : dt_rd_reg;
        xe     = sat(ext(od_rd_reg) - ((ext(dp_inv) + ext(s1_x_reg) + ROUND_Q) >>> 2));

        even_we = s1_valid_reg && (s1_fwd ? s1_even : !s1_even);
        odd_we  = s1_valid_reg && (s1_fwd ? (!s1_even && !s1_ctrl_reg.last_row) : s1_even);
        det_we  = s1_valid_reg && emit;
        even_wd = s1_fwd ? s1_x_reg : xe;
        det_wd  = s1_fwd ? d_fwd : s1_x_reg;

        grp_next.col   = 8'(s1_col_reg);
        grp_next.frame = s1_ctrl_reg.last_row && s1_ctrl_reg.last_col;
        if (s1_fwd)
        begin
            grp_next.row   = s1_even ? (s1_ctrl_reg.row - 8'd2) : (s1_ctrl_reg.row - 8'd1);
            grp_next.count = 2'd2;
        end
        else
        begin
            grp_next.row = has_xo ? (s1_ctrl_reg.row - 8'd2) : (s1_ctrl_reg.row - 8'd1);
            if (has_xo)
            begin
                grp_next.count = s1_ctrl_reg.last_row ? 2'd3 : 2'd2;
            end
            else
            begin
                grp_next.count = s1_ctrl_reg.last_row ? 2'd2 : 2'd1;
            end
        end
    end

    // ---- line stores: one write, one registered read with write bypass ----
    always_ff @(posedge clk)
    begin
        if (even_we)
        begin
            even_mem[s1_col_reg] <= even_wd;
        end
        if (accept)
        begin
            ev_rd_reg <= (even_we && (s1_col_reg == col_in)) ? even_wd : even_mem[col_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (odd_we)
        begin
            odd_mem[s1_col_reg] <= s1_x_reg;
        end
        if (accept)
        begin
            od_rd_reg <= (odd_we && (s1_col_reg == col_in)) ? s1_x_reg : odd_mem[col_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (det_we)
        begin
            detail_mem[s1_col_reg] <= det_wd;
        end
        if (accept)
        begin
            dt_rd_reg <= (det_we && (s1_col_reg == col_in)) ? det_wd : detail_mem[col_in];
        end
    end

    // ---- pipeline registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= x_in;
            s1_col_reg  <= col_in;
            s1_ctrl_reg <= ctrl_in;
        end
        if (s1_valid_reg && emit)
        begin
            s2_a_reg    <= ev_rd_reg;
            s2_c_reg    <= s1_fwd ? d_fwd : xe;
            s2_dt_reg   <= dt_rd_reg;
            s2_x_reg    <= s1_x_reg;
            s2_self_reg <= use_self && s1_fwd;
            s2_inv_reg  <= !s1_fwd;
            s2_xo_reg   <= has_xo;
            s2_grp_reg  <= grp_next;
        end
    end

    // ---- stage two: update (forward) or predict undo (inverse) ----
    always_comb
    begin
        s2_b    = s2_self_reg ? s2_c_reg : s2_dt_reg;
        s_val   = sat(ext(s2_a_reg) + ((ext(s2_b) + ext(s2_c_reg) + ROUND_Q) >>> 2));
        xo_val  = sat(ext(s2_b) + ((ext(s2_a_reg) + ext(s2_c_reg)) >>> 1));
        fin_val = sat(ext(s2_x_reg) + ext(s2_c_reg));

        if (!s2_inv_reg)
        begin
            vals = {s2_c_reg, s2_c_reg, s_val};
        end
        else if (s2_xo_reg)
        begin
            vals = {fin_val, s2_c_reg, xo_val};
        end
        else
        begin
            vals = {fin_val, fin_val, s2_c_reg};
        end
    end

    assign push = s2_valid_reg;
    assign grp  = s2_grp_reg;
    assign busy = {s2_valid_reg, s1_valid_reg};

endmodule

// ===== hw/rtl/v53lw_out_fifo.sv =====
// ----------------------------------------------------------------------------
// v53lw_out_fifo
// Queue of result groups with a prefetch stage and a head register that
// hands out the results of the head group one transaction at a time.
// ----------------------------------------------------------------------------
module v53lw_out_fifo #(
    parameter int SAMPLE_BITS = v53lw_pkg::SAMPLE_BITS_DEF,
    parameter int ADDR_BITS   = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  v53lw_pkg::grp_ctrl_t     grp,
    input  logic [3*SAMPLE_BITS-1:0] vals,
    output logic [ADDR_BITS:0]       level,
    v53lw_out_if.source              results
);
    import v53lw_pkg::*;

    localparam int DEPTH = 2 ** ADDR_BITS;
    localparam int GW    = $bits(grp_ctrl_t);
    localparam int VW    = 3 * SAMPLE_BITS;
    localparam int EW    = GW + VW;

    logic [EW-1:0] mem [DEPTH];

    logic [ADDR_BITS-1:0] wr_ptr_reg;
    logic [ADDR_BITS-1:0] rd_ptr_reg;
    logic [ADDR_BITS:0]   level_reg;
    logic [ADDR_BITS:0]   level_next;
    logic                 pf_valid_reg;
    logic                 pf_valid_next;
    logic [EW-1:0]        pf_reg;
    logic                 head_valid_reg;
    logic                 head_valid_next;
    grp_ctrl_t            head_grp_reg;
    logic [VW-1:0]        head_vals_reg;
    logic [1:0]           idx_reg;
    logic [1:0]           idx_next;

    logic head_last;
    logic out_fire;
    logic head_done;
    logic head_load;
    logic pf_load;

    always_comb
    begin
        head_last = idx_reg == (head_grp_reg.count - 2'd1);
        out_fire  = head_valid_reg && results.ready;
        head_done = out_fire && head_last;
        head_load = pf_valid_reg && (!head_valid_reg || head_done);
        pf_load   = (level_reg != '0) && (!pf_valid_reg || head_load);

        case ({push, pf_load})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase

        pf_valid_next   = pf_load ? 1'b1 : (head_load ? 1'b0 : pf_valid_reg);
        head_valid_next = head_load ? 1'b1 : (head_done ? 1'b0 : head_valid_reg);
        idx_next        = head_load ? 2'd0 : (out_fire ? idx_reg + 2'd1 : idx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= {grp, vals};
        end
        if (pf_load)
        begin
            pf_reg <= mem[rd_ptr_reg];
        end
        if (head_load)
        begin
            head_grp_reg  <= grp_ctrl_t'(pf_reg[EW-1 -: GW]);
            head_vals_reg <= pf_reg[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            level_reg      <= '0;
            pf_valid_reg   <= 1'b0;
            head_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pf_load)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg      <= level_next;
            pf_valid_reg   <= pf_valid_next;
            head_valid_reg <= head_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    results.sample_out = head_vals_reg[SAMPLE_BITS-1:0];
            2'd1:    results.sample_out = head_vals_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
            default: results.sample_out = head_vals_reg[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
        endcase
    end

    assign results.valid      = head_valid_reg;
    assign results.out_row    = head_grp_reg.row + 8'(idx_reg);
    assign results.out_col    = head_grp_reg.col;
    assign results.run_last   = head_last;
    assign results.frame_done = head_last && head_grp_reg.frame;
    assign level              = level_reg;

endmodule

// ===== hw/rtl/vertical_53_lifting_wavelet.sv =====
// ----------------------------------------------------------------------------
// vertical_53_lifting_wavelet
// One vertical level of the reversible 5/3 lifting wavelet, forward or
// inverse, on a row-major sample stream, with tagged interleaved results.
// ----------------------------------------------------------------------------
// One sample per cycle in and one result per cycle out when nothing stalls.
// Results pass the core stages, the queue, the prefetch and the head register.
// Input stalls only when queued plus in-flight groups would fill the queue.
// Reset clears configuration, position counters, pipeline and queue; the
// line stores are not cleared and hold nothing meaningful until written.
module vertical_53_lifting_wavelet #(
    parameter int MAX_WIDTH   = v53lw_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = v53lw_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    v53lw_in_if.sink                              samples,
    v53lw_out_if.source                           results,
    input  logic                                  cfg_we,
    input  logic [v53lw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [v53lw_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import v53lw_pkg::*;

    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW1      = COL_BITS + 1;
    localparam int FIFO_AW  = COL_BITS + 1;
    localparam int LW       = FIFO_AW + 2;

    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;
    logic                     inverse_reg;

    logic [ROW_BITS-1:0] row_reg;
    logic [ROW_BITS-1:0] row_next;
    logic [COL_BITS-1:0] col_reg;
    logic [COL_BITS-1:0] col_next;

    logic [CW1-1:0]           w_eff;
    logic [CFG_DATA_BITS-1:0] h_lim;
    logic [CFG_DATA_BITS-1:0] h_even;
    logic [CFG_DATA_BITS-1:0] h_eff;
    logic                     row_wrap;
    logic [ROW_BITS-1:0]      cur_row;
    logic [COL_BITS-1:0]      cur_col;
    logic [CW1-1:0]           col_inc;
    logic [CFG_DATA_BITS-1:0] row_inc;
    item_ctrl_t               item_ctrl;

    logic                     accept;
    logic                     push;
    grp_ctrl_t                grp;
    logic [3*SAMPLE_BITS-1:0] vals;
    logic [1:0]               busy;
    logic [FIFO_AW:0]         level;
    logic [LW-1:0]            occupancy;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            inverse_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg   <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg  <= cfg_data;
                REG_INVERSE_MODE: inverse_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // frame geometry and position
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = CW1'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = CW1'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW1'(width_reg);
        end

        h_lim  = (int'(height_reg) > HEIGHT_LIMIT) ? CFG_DATA_BITS'(HEIGHT_LIMIT) : height_reg;
        h_even = {h_lim[CFG_DATA_BITS-1:1], 1'b0};
        h_eff  = (h_even < 9'd2) ? 9'd2 : h_even;

        row_wrap = {1'b0, row_reg} >= h_eff;
        cur_row  = row_wrap ? '0 : row_reg;
        cur_col  = (row_wrap || ({1'b0, col_reg} >= w_eff)) ? '0 : col_reg;

        item_ctrl.row      = cur_row;
        item_ctrl.last_row = {1'b0, cur_row} == (h_eff - 9'd1);
        item_ctrl.last_col = {1'b0, cur_col} == (w_eff - CW1'(1));
        item_ctrl.inverse  = inverse_reg;

        col_inc = {1'b0, cur_col} + CW1'(1);
        row_inc = {1'b0, cur_row} + 9'd1;
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_BITS-1:0];
        end
        else
        begin
            col_next = col_inc[COL_BITS-1:0];
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // each sample in flight may still add one group to the queue
    always_comb
    begin
        occupancy = LW'(level) + LW'(busy[0]) + LW'(busy[1]);
    end

    assign samples.ready = occupancy < LW'(2 ** FIFO_AW);
    assign accept        = samples.valid && samples.ready;

    v53lw_core #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COL_BITS    (COL_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .x_in    (samples.sample_in),
        .col_in  (cur_col),
        .ctrl_in (item_ctrl),
        .push    (push),
        .grp     (grp),
        .vals    (vals),
        .busy    (busy)
    );

    v53lw_out_fifo #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (FIFO_AW)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .grp     (grp),
        .vals    (vals),
        .level   (level),
        .results (results)
    );

endmodule

// ===== hw/rtl/v53lw_checker.sv =====
// ----------------------------------------------------------------------------
// v53lw_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module v53lw_checker #(
    parameter int SAMPLE_BITS = v53lw_pkg::SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] sample_out,
    input logic [7:0]                    out_row,
    input logic [7:0]                    out_col,
    input logic                          run_last,
    input logic                          frame_done
);

    // a stalled transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(out_row)
            && $stable(out_col) && $stable(run_last) && $stable(frame_done))
        else $error("result changed while stalled");

    // end of frame is the last result of its sample and lies on an odd row
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> run_last && out_row[0])
        else $error("frame_done on a wrong result");

    // results of one sample follow back to back down the same column
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=>
            out_valid && (out_col == $past(out_col)) && (out_row == $past(out_row) + 8'd1))
        else $error("broken result run");

endmodule

bind vertical_53_lifting_wavelet v53lw_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_v53lw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .sample_out (results.sample_out),
    .out_row    (results.out_row),
    .out_col    (results.out_col),
    .run_last   (results.run_last),
    .frame_done (results.frame_done)
);

// ===== dv/vertical_53_lifting_wavelet_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_53_lifting_wavelet_test
// Streams frames of samples through the vertical 5/3 lifting block, forward
// and inverse, across a range of image sizes including out-of-range register
// values and mid-frame register changes. A local predictor of the lifting
// steps, line stores and row/column tagging builds the expected result
// stream, which every result transaction is checked against field by field.
// Both channels stall at random.
// ----------------------------------------------------------------------------
module vertical_53_lifting_wavelet_test;

    import v53lw_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 380;

    localparam logic MODE_FORWARD = 1'b0;
    localparam logic MODE_INVERSE = 1'b1;

    localparam logic signed [SAMPLE_BITS_DEF-1:0] S_MAX = 2**(SAMPLE_BITS_DEF-1) - 1;
    localparam logic signed [SAMPLE_BITS_DEF-1:0] S_MIN = -(2**(SAMPLE_BITS_DEF-1));

    typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

    typedef struct {
        sample_t    sample;
        logic [7:0] row;
        logic [7:0] col;
        logic       run_last;
        logic       frame_done;
    } lifted_sample_t;

    typedef enum {SLOW_RECEIVER, SLOW_SENDER, FULL_RATE} idle_plan_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid  = 1'b0;
    sample_t                   in_sample = '0;
    logic                      out_ready = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    sample_t        pending_samples[$];
    lifted_sample_t expected_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int stall_cycles  = 0;

    // predictor copy of the registers, line stores and stream position
    logic [CFG_DATA_BITS-1:0] cur_width   = WIDTH_RESET;
    logic [CFG_DATA_BITS-1:0] cur_height  = HEIGHT_RESET;
    logic                     cur_inverse = MODE_FORWARD;
    longint                   even_line[MAX_WIDTH_DEF];
    longint                   odd_line[MAX_WIDTH_DEF];
    longint                   detail_line[MAX_WIDTH_DEF];
    int                       row_pos = 0;
    int                       col_pos = 0;

    v53lw_in_if  sample_ch ();
    v53lw_out_if result_ch ();

    assign sample_ch.valid     = in_valid;
    assign sample_ch.sample_in = in_sample;
    assign result_ch.ready     = out_ready;

    vertical_53_lifting_wavelet i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_width(input logic [CFG_DATA_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_WIDTH_DEF)
            return MAX_WIDTH_DEF;
        return int'(v);
    endfunction

    function automatic int eff_height(input logic [CFG_DATA_BITS-1:0] v);
        int h;
        h = (v > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(v);
        h = h & ~1;
        return (h < 2) ? 2 : h;
    endfunction

    function automatic longint clip(input longint v);
        if (v > S_MAX)
            return S_MAX;
        if (v < S_MIN)
            return S_MIN;
        return v;
    endfunction

    function automatic void lift_predict(input sample_t sample);
        int             w;
        int             h;
        int             r;
        int             c;
        int             n;
        longint         x;
        longint         d;
        longint         dp;
        longint         xe;
        longint         vals[3];
        int             rows[3];
        bit             last_row;
        bit             last_col;
        lifted_sample_t res;
        w = eff_width(cur_width);
        h = eff_height(cur_height);
        if (row_pos >= h)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w)
            col_pos = 0;
        r = row_pos;
        c = col_pos;
        n = 0;
        x = sample;
        last_row = (r == h - 1);
        last_col = (c == w - 1);
        if (cur_inverse == MODE_FORWARD)
        begin
            if (r % 2 == 0)
            begin
                if (r != 0)
                begin
                    d  = clip(odd_line[c] - ((even_line[c] + x) >>> 1));
                    dp = (r == 2) ? d : detail_line[c];
                    vals[0] = clip(even_line[c] + ((dp + d + 2) >>> 2));
                    rows[0] = r - 2;
                    vals[1] = d;
                    rows[1] = r - 1;
                    n = 2;
                    detail_line[c] = d;
                end
                even_line[c] = x;
            end
            else if (last_row)
            begin
                d  = clip(x - even_line[c]);
                dp = (r == 1) ? d : detail_line[c];
                vals[0] = clip(even_line[c] + ((dp + d + 2) >>> 2));
                rows[0] = r - 1;
                vals[1] = d;
                rows[1] = r;
                n = 2;
                detail_line[c] = d;
            end
            else
                odd_line[c] = x;
        end
        else
        begin
            if (r % 2 == 0)
                odd_line[c] = x;
            else
            begin
                d  = x;
                dp = (r == 1) ? d : detail_line[c];
                xe = clip(odd_line[c] - ((dp + d + 2) >>> 2));
                if (r > 1)
                begin
                    vals[n] = clip(dp + ((even_line[c] + xe) >>> 1));
                    rows[n] = r - 2;
                    n++;
                end
                vals[n] = xe;
                rows[n] = r - 1;
                n++;
                if (last_row)
                begin
                    vals[n] = clip(d + xe);
                    rows[n] = r;
                    n++;
                end
                even_line[c]   = xe;
                detail_line[c] = d;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            res.sample     = vals[i][SAMPLE_BITS_DEF-1:0];
            res.row        = rows[i][7:0];
            res.col        = c[7:0];
            res.run_last   = (i == n - 1);
            res.frame_done = (i == n - 1) && last_row && last_col;
            expected_results.push_back(res);
        end
        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    function automatic sample_t pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return sample_t'($urandom());
        if (sel < 60)
            return sample_t'($urandom_range(256) - 128);
        if (sel < 75)
        begin
            case ($urandom_range(3))
                0:       return S_MAX;
                1:       return S_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return sample_t'($urandom_range(1023));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // sender side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_sample <= '0;
        end
        else
        begin
            if (in_valid && sample_ch.ready)
                lift_predict(in_sample);
            if (!in_valid || sample_ch.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid  <= 1'b1;
                    in_sample <= pending_samples.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver side and result check
    always @(posedge clk or negedge rst_n)
    begin
        lifted_sample_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (result_ch.valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected transaction row %0d col %0d",
                                              result_ch.out_row, result_ch.out_col));
                else
                begin
                    want = expected_results.pop_front();
                    if (result_ch.sample_out !== want.sample)
                        report_mismatch($sformatf("sample_out %0d, expected %0d (row %0d col %0d)",
                                                  result_ch.sample_out, want.sample,
                                                  want.row, want.col));
                    if (result_ch.out_row !== want.row)
                        report_mismatch($sformatf("out_row %0d, expected %0d (col %0d)",
                                                  result_ch.out_row, want.row, want.col));
                    if (result_ch.out_col !== want.col)
                        report_mismatch($sformatf("out_col %0d, expected %0d (row %0d)",
                                                  result_ch.out_col, want.col, want.row));
                    if (result_ch.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %0b, expected %0b (row %0d col %0d)",
                                                  result_ch.run_last, want.run_last,
                                                  want.row, want.col));
                    if (result_ch.frame_done !== want.frame_done)
                        report_mismatch($sformatf("frame_done %0b, expected %0b (row %0d col %0d)",
                                                  result_ch.frame_done, want.frame_done,
                                                  want.row, want.col));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && sample_ch.ready) || (result_ch.valid && out_ready) || cfg_we)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic drain();
        @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            REG_IMAGE_WIDTH:  cur_width   = data;
            REG_IMAGE_HEIGHT: cur_height  = data;
            REG_INVERSE_MODE: cur_inverse = data[0];
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_frame(input logic [CFG_DATA_BITS-1:0] w,
                             input logic [CFG_DATA_BITS-1:0] h, input logic mode);
        drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_INVERSE_MODE, {{(CFG_DATA_BITS-1){1'b0}}, mode});
    endtask

    task automatic begin_burst(input idle_plan_t plan);
        @(negedge clk);
        case (plan)
            SLOW_RECEIVER:
            begin
                send_idle_pct = 15;
                recv_idle_pct = 87;
            end
            SLOW_SENDER:
            begin
                send_idle_pct = 87;
                recv_idle_pct = 15;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic load_random(input int count);
        for (int i = 0; i < count; i++)
            pending_samples.push_back(pick_sample());
    endtask

    // send count samples, pausing once part way until every result is back
    task automatic load_split(input int count, input idle_plan_t plan);
        int head;
        head = $urandom_range(count - 1, 1);
        begin_burst(plan);
        load_random(head);
        drain();
        begin_burst(plan);
        load_random(count - head);
    endtask

    initial
    begin
        sample_t    fwd_edges[12];
        sample_t    inv_edges[10];
        int         random_done;
        int         w;
        int         h;
        int         n;
        idle_plan_t plan;

        fwd_edges = '{S_MAX, S_MIN, '0,
                      S_MIN, S_MAX, '1,
                      S_MAX, S_MIN, 1,
                      S_MIN, S_MAX, '0};
        inv_edges = '{S_MAX, S_MIN, '1,
                      S_MIN, S_MAX, '0,
                      S_MAX, S_MIN, S_MAX, S_MIN};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: saturating extremes, forward then inverse
        set_frame(3, 4, MODE_FORWARD);
        begin_burst(SLOW_RECEIVER);
        foreach (fwd_edges[i])
            pending_samples.push_back(fwd_edges[i]);
        set_frame(3, 2, MODE_INVERSE);
        begin_burst(SLOW_RECEIVER);
        for (int i = 0; i < 6; i++)
            pending_samples.push_back(inv_edges[i]);
        set_frame(1, 4, MODE_INVERSE);
        begin_burst(SLOW_RECEIVER);
        for (int i = 6; i < 10; i++)
            pending_samples.push_back(inv_edges[i]);

        random_done = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            if (random_done < RANDOM_ITEMS / 3)
                plan = SLOW_RECEIVER;
            else if (random_done < 2 * RANDOM_ITEMS / 3)
                plan = SLOW_SENDER;
            else
                plan = FULL_RATE;
            w = ($urandom_range(4) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 0);
            h = $urandom_range(10, 0);
            set_frame(w[CFG_DATA_BITS-1:0], h[CFG_DATA_BITS-1:0],
                      $urandom_range(1) ? MODE_INVERSE : MODE_FORWARD);
            n = eff_width(w[CFG_DATA_BITS-1:0]) * eff_height(h[CFG_DATA_BITS-1:0]);
            if ($urandom_range(3) == 0)
                load_split(n, plan);
            else
            begin
                begin_burst(plan);
                load_random(n);
            end
            random_done += n;
        end

        // register values beyond the limits: zero width, oversize height and width
        set_frame(0, 511, MODE_FORWARD);
        begin_burst(FULL_RATE);
        load_random(256);
        set_frame(511, 1, MODE_INVERSE);
        begin_burst(FULL_RATE);
        load_random(512);

        // mode switched mid-frame, all stores already written at this width
        set_frame(4, 4, MODE_FORWARD);
        begin_burst(FULL_RATE);
        load_random(16);
        set_frame(4, 4, MODE_INVERSE);
        begin_burst(FULL_RATE);
        load_random(16);
        set_frame(4, 4, MODE_FORWARD);
        begin_burst(FULL_RATE);
        load_random(8);
        drain();
        write_reg(REG_INVERSE_MODE, {{(CFG_DATA_BITS-1){1'b0}}, MODE_INVERSE});
        begin_burst(FULL_RATE);
        load_random(8);

        // height cut below the current row: frame restarts at the top
        set_frame(4, 6, MODE_FORWARD);
        begin_burst(FULL_RATE);
        load_random(16);
        drain();
        write_reg(REG_IMAGE_HEIGHT, 2);
        begin_burst(FULL_RATE);
        load_random(8);

        // width cut below the current column: column wraps to zero
        set_frame(6, 4, MODE_FORWARD);
        begin_burst(FULL_RATE);
        load_random(9);
        drain();
        write_reg(REG_IMAGE_WIDTH, 2);
        begin_burst(FULL_RATE);
        load_random(6);

        drain();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
